### rtl/assert_macros.svh
// Assertion macros used by the checker file imt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

### rtl/imt_pkg.sv
// Package for the iterative mean threshold block: widths, states, status codes.
// No dependencies.
package imt_pkg;
  localparam int PIXEL_BITS = 12;
  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int GREY_LEVELS = 1 << PIXEL_BITS;
  localparam int CNT_W = MAX_PIXELS_LOG2;
  localparam int SUM_W = CNT_W + PIXEL_BITS;
  localparam logic [CNT_W-1:0] PIXEL_CAP = {CNT_W{1'b1}};
  localparam logic [15:0] INIT_THR_RST = 16'd128;
  localparam logic [7:0] ITER_LIM_RST = 8'd64;
  localparam logic CFG_INIT_THR = 1'b0;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_NO_ABOVE  = 2'd1,
    ST_NO_BELOW  = 2'd2,
    ST_LIMIT     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_COLLECT, S_CLEAR, S_START, S_SPLIT, S_SPLIT_LAST, S_DIV_A, S_DIV_B,
    S_UPDATE, S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quo;
  } div_rsp_t;
endpackage

### rtl/imt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module imt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/imt_div.sv
// Restoring divider, one quotient bit per cycle, shared by both class means.
// Depends on imt_pkg.
module imt_div import imt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int CW = $clog2(SUM_W + 1);
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W:0]   trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    if (req.start) begin
      quo_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = CW'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = quo_r;
endmodule

### rtl/iterative_mean_threshold.sv
// Top level of the iterative mean threshold block: histogram, sequencer, outputs.
// Depends on imt_pkg, imt_ram, imt_div.
//
//  channel | direction | handshake       | payload
//  in_     | input     | valid / stall   | pixel_value, last_pixel
//  out_    | output    | valid / stall   | threshold, means, iterations, status
//  cfg_    | input     | valid / ready   | index, data
//
// Each counted pixel is a histogram read, then the write of the count with in_stall
// high. After the last pixel each round sweeps 4096 histogram entries (one per
// cycle), then runs two divisions and an update. The histogram is cleared by a
// sweep of all 4096 entries after reset and after each image, with in_stall high.
// A result waits in the output register; the sweep of the next image overlaps
// with it, and a newer result holds in S_DONE until the old one is taken.
module iterative_mean_threshold import imt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pixel_value,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_threshold,
  output logic [11:0] out_mean_above,
  output logic [11:0] out_mean_below,
  output logic [7:0]  out_iterations,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = PIXEL_BITS;

  state_t state_r, state_nxt;
  logic [15:0] init_thr_r;
  logic [7:0]  iter_lim_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic [7:0]  iter_r, iter_nxt;
  logic [SUM_W-1:0] sum_a_r, sum_a_nxt, sum_b_r, sum_b_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [AW-1:0] scan_v_r;
  logic scan_valid_r;
  logic [AW-1:0] mean_a_r, mean_a_nxt, mean_b_r, mean_b_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [11:0] o_thr_r, o_ma_r, o_mb_r;
  logic [7:0] o_it_r;
  status_t o_st_r;
  status_t st_keep_r;
  logic load_out;
  logic [11:0] l_thr, l_ma, l_mb;
  logic [7:0] l_it;
  status_t l_st;

  // Histogram update: read request, then write of the incremented count.
  logic p1_v_r;
  logic [AW-1:0] p1_a_r;
  logic [CNT_W-1:0] rdata, wcnt;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [CNT_W-1:0] ram_wdata;
  logic accept, count_it;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [SUM_W-1:0] prod;
  logic [16:0] new_thr;

  assign accept = in_valid && !in_stall;
  assign count_it = accept && (total_r != PIXEL_CAP);

  assign wcnt = rdata + CNT_W'(1);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = addr_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (p1_v_r) begin
      ram_we = 1'b1;
      ram_addr = p1_a_r;
      ram_wdata = wcnt;
    end else if (count_it) begin
      ram_addr = in_pixel_value[AW-1:0];
    end
  end

  imt_ram #(.WIDTH(CNT_W), .DEPTH(GREY_LEVELS)) u_hist (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
  );

  imt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign prod = SUM_W'(rdata) * SUM_W'(scan_v_r);
  assign new_thr = {5'd0, mean_a_r} + {5'd0, mean_b_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_COLLECT: if (accept && in_last_pixel) state_nxt = S_START;
      S_CLEAR: if (addr_r == AW'(GREY_LEVELS - 1)) state_nxt = S_COLLECT;
      S_START: if (!p1_v_r) state_nxt = S_SPLIT;
      S_SPLIT: if (addr_r == AW'(GREY_LEVELS - 1)) state_nxt = S_SPLIT_LAST;
      S_SPLIT_LAST: state_nxt = S_DIV_A;
      S_DIV_A: if (drsp.done) state_nxt = S_DIV_B;
      S_DIV_B: if (drsp.done) state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (cnt_a_r == '0 || cnt_b_r == '0) state_nxt = S_DONE;
        else if (new_thr[16:1] == thr_r) state_nxt = S_DONE;
        else if ({iter_r + 8'd1} >= iter_lim_r) state_nxt = S_DONE;
        else state_nxt = S_SPLIT;
      end
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_CLEAR;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    addr_nxt = addr_r;
    total_nxt = total_r;
    thr_nxt = thr_r;
    iter_nxt = iter_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    mean_a_nxt = mean_a_r;
    mean_b_nxt = mean_b_r;
    dreq = '0;
    load_out = 1'b0;
    l_thr = thr_r[11:0];
    l_ma = 12'(mean_a_r);
    l_mb = 12'(mean_b_r);
    l_it = iter_r;
    l_st = ST_CONVERGED;
    case (state_r)
      S_COLLECT: if (count_it) total_nxt = total_r + CNT_W'(1);
      S_CLEAR: begin
        addr_nxt = addr_r + AW'(1);
        total_nxt = '0;
      end
      S_START: begin
        thr_nxt = init_thr_r;
        iter_nxt = '0;
        addr_nxt = '0;
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
      end
      S_SPLIT, S_SPLIT_LAST: begin
        if (state_r == S_SPLIT) addr_nxt = addr_r + AW'(1);
        if (scan_valid_r) begin
          if (16'(scan_v_r) > thr_r) begin
            sum_a_nxt = sum_a_r + prod;
            cnt_a_nxt = cnt_a_r + rdata;
          end else begin
            sum_b_nxt = sum_b_r + prod;
            cnt_b_nxt = cnt_b_r + rdata;
          end
        end
        if (state_r == S_SPLIT_LAST) begin
          dreq.start = 1'b1;
          dreq.num = sum_a_nxt;
          dreq.den = cnt_a_nxt;
        end
      end
      S_DIV_A: if (drsp.done) begin
        mean_a_nxt = (cnt_a_r == '0) ? '0 : AW'(drsp.quo);
        dreq.start = 1'b1;
        dreq.num = sum_b_r;
        dreq.den = cnt_b_r;
      end
      S_DIV_B: if (drsp.done) begin
        mean_b_nxt = (cnt_b_r == '0) ? '0 : AW'(drsp.quo);
        if (cnt_a_r == '0) mean_a_nxt = '0;
      end
      S_UPDATE: begin
        addr_nxt = '0;
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        if (cnt_a_r == '0) begin
          mean_a_nxt = '0;
          l_st = ST_NO_ABOVE;
        end else if (cnt_b_r == '0) begin
          mean_b_nxt = '0;
          l_st = ST_NO_BELOW;
        end else begin
          thr_nxt = new_thr[16:1];
          iter_nxt = iter_r + 8'd1;
          l_st = (new_thr[16:1] == thr_r) ? ST_CONVERGED : ST_LIMIT;
        end
      end
      S_DONE: begin
        l_st = st_keep_r;
        load_out = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      total_r <= '0;
      init_thr_r <= INIT_THR_RST;
      iter_lim_r <= ITER_LIM_RST;
      out_valid_r <= 1'b0;
      p1_v_r <= 1'b0;
      scan_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      total_r <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_INIT_THR) init_thr_r <= cfg_data;
        else iter_lim_r <= cfg_data[7:0];
      end
      out_valid_r <= out_valid_nxt;
      p1_v_r <= count_it;
      scan_valid_r <= (state_r == S_SPLIT);
    end
    p1_a_r <= in_pixel_value[AW-1:0];
    scan_v_r <= addr_r;
    thr_r <= thr_nxt;
    iter_r <= iter_nxt;
    sum_a_r <= sum_a_nxt;
    sum_b_r <= sum_b_nxt;
    cnt_a_r <= cnt_a_nxt;
    cnt_b_r <= cnt_b_nxt;
    mean_a_r <= mean_a_nxt;
    mean_b_r <= mean_b_nxt;
    if (state_r == S_UPDATE) st_keep_r <= l_st;
    if (load_out) begin
      o_thr_r <= l_thr;
      o_ma_r <= l_ma;
      o_mb_r <= l_mb;
      o_it_r <= l_it;
      o_st_r <= l_st;
    end
  end

  // Result goes out from S_DONE on, once the old one is taken.
  assign out_valid_nxt = (out_valid_r && out_stall) || (state_r == S_DONE &&
                         (!out_valid_r || !out_stall));
  assign in_stall = (state_r != S_COLLECT) || p1_v_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_threshold = o_thr_r;
  assign out_mean_above = o_ma_r;
  assign out_mean_below = o_mb_r;
  assign out_iterations = o_it_r;
  assign out_status = o_st_r;
endmodule

### rtl/imt_checker.sv
// Port-level checker for iterative_mean_threshold, bound to the top level.
// Depends on imt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module imt_checker import imt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_pixel,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_threshold,
  input logic [1:0]  out_status,
  input logic [7:0]  out_iterations
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_threshold))
  `CHK_NEXT(a_last_stalls, clk, rst_n, in_valid && !in_stall && in_last_pixel, in_stall)
  `CHK_IMPL(a_conv_iter, clk, rst_n, out_valid && out_status == ST_CONVERGED, out_iterations != 8'd0)
  `CHK_IMPL(a_limit_iter, clk, rst_n, out_valid && out_status == ST_LIMIT, out_iterations != 8'd0)
endmodule

bind iterative_mean_threshold imt_checker u_imt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_last_pixel(in_last_pixel), .out_valid(out_valid), .out_stall(out_stall),
  .out_threshold(out_threshold), .out_status(out_status),
  .out_iterations(out_iterations)
);

### sim/tb.sv
// Testbench for iterative_mean_threshold: directed and random images with random handshake gaps.
// Depends on imt_pkg and the iterative_mean_threshold RTL.
// A scoreboard class predicts each image result and checks the output stream.
`timescale 1ns / 100ps

module tb;
  import imt_pkg::*;

  localparam logic CFG_ITER_LIM = ~CFG_INIT_THR;

  typedef struct {
    logic [11:0] threshold;
    logic [11:0] mean_above;
    logic [11:0] mean_below;
    logic [7:0]  iterations;
    status_t     status;
  } thr_result_t;

  class thr_scoreboard;
    logic [11:0]  pixels[$];
    thr_result_t  expected[$];
    logic [15:0]  init_thr = INIT_THR_RST;
    logic [7:0]   iter_lim = ITER_LIM_RST;
    int           errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CFG_INIT_THR) init_thr = data;
      else iter_lim = data[7:0];
    endfunction

    function void note_pixel(logic [11:0] p, logic last);
      logic [15:0] cur, prev;
      logic [7:0] cnt;
      longint sa, sb, ca, cb, ma, mb;
      status_t st;
      thr_result_t r;
      if (pixels.size() < PIXEL_CAP) pixels.push_back(p);
      if (!last) return;
      cur = init_thr;
      cnt = 0;
      forever begin
        sa = 0; sb = 0; ca = 0; cb = 0;
        foreach (pixels[i]) begin
          if ({4'd0, pixels[i]} > cur) begin
            sa += pixels[i]; ca++;
          end else begin
            sb += pixels[i]; cb++;
          end
        end
        if (ca == 0) begin
          ma = 0; mb = (cb != 0) ? sb / cb : 0; st = ST_NO_ABOVE;
          break;
        end
        if (cb == 0) begin
          ma = sa / ca; mb = 0; st = ST_NO_BELOW;
          break;
        end
        ma = sa / ca;
        mb = sb / cb;
        prev = cur;
        cur = 16'((ma + mb) >> 1);
        cnt = cnt + 8'd1;
        if (cur == prev) begin
          st = ST_CONVERGED;
          break;
        end
        if (cnt >= iter_lim) begin
          st = ST_LIMIT;
          break;
        end
      end
      r.threshold = cur[11:0];
      r.mean_above = ma[11:0];
      r.mean_below = mb[11:0];
      r.iterations = cnt;
      r.status = st;
      expected.push_back(r);
      pixels.delete();
    endfunction

    task check_result(thr_result_t got);
      thr_result_t e;
      if (expected.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = expected.pop_front();
      if (got.threshold !== e.threshold)
        report($sformatf("threshold %0d exp %0d", got.threshold, e.threshold));
      if (got.mean_above !== e.mean_above)
        report($sformatf("mean_above %0d exp %0d", got.mean_above, e.mean_above));
      if (got.mean_below !== e.mean_below)
        report($sformatf("mean_below %0d exp %0d", got.mean_below, e.mean_below));
      if (got.iterations !== e.iterations)
        report($sformatf("iterations %0d exp %0d", got.iterations, e.iterations));
      if (got.status !== e.status)
        report($sformatf("status %0d exp %0d", got.status, e.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pixel_value = '0;
  logic        in_last_pixel = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_threshold;
  logic [11:0] out_mean_above;
  logic [11:0] out_mean_below;
  logic [7:0]  out_iterations;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  thr_scoreboard sb = new();
  int pixels_sent = 0;

  iterative_mean_threshold uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(200, 20);
  endfunction

  task automatic send_pixel(logic [11:0] p, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= p;
    in_last_pixel <= last;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p, last);
    pixels_sent++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (4300) @(posedge clk);
  endtask

  task automatic setup(logic [15:0] thr, logic [15:0] lim);
    drain();
    write_reg(CFG_INIT_THR, thr);
    write_reg(CFG_ITER_LIM, lim);
  endtask

  function automatic logic [11:0] rand_pixel(int mode, logic [11:0] center);
    case (mode)
      0: return 12'($urandom);
      1: return ($urandom_range(1)) ? 12'($urandom_range(7)) : 12'(4088 + $urandom_range(7));
      default: return center + 12'($urandom_range(63));
    endcase
  endfunction

  task automatic send_image(int size);
    int mode;
    logic [11:0] c1, c2;
    mode = $urandom_range(3);
    c1 = 12'($urandom);
    c2 = 12'($urandom);
    for (int i = 0; i < size; i++) begin
      if (mode == 3) send_pixel(rand_pixel(2, $urandom_range(1) ? c1 : c2), i == size - 1);
      else send_pixel(rand_pixel(mode, c1), i == size - 1);
    end
  endtask

  always @(posedge clk) begin
    thr_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.threshold = out_threshold;
      r.mean_above = out_mean_above;
      r.mean_below = out_mean_below;
      r.iterations = out_iterations;
      r.status = status_t'(out_status);
      sb.check_result(r);
    end
  end

  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    setup(16'd128, 16'd64);
    send_pixel(12'd0, 1'b1);
    send_pixel(12'd4095, 1'b1);
    send_pixel(12'd0, 1'b0);
    send_pixel(12'd4095, 1'b1);
    send_pixel(12'hAAA, 1'b0);
    send_pixel(12'h555, 1'b0);
    send_pixel(12'd128, 1'b0);
    send_pixel(12'd129, 1'b1);

    setup(16'hFFFF, 16'hFF05);
    send_pixel(12'd4095, 1'b0);
    send_pixel(12'd0, 1'b1);

    setup(16'd0, 16'd0);
    send_pixel(12'd0, 1'b0);
    send_pixel(12'd0, 1'b1);
    send_pixel(12'd1, 1'b0);
    send_pixel(12'd100, 1'b0);
    send_pixel(12'd4000, 1'b1);

    setup(16'd4095, 16'd1);
    send_pixel(12'd10, 1'b0);
    send_pixel(12'd3000, 1'b0);
    send_pixel(12'd4095, 1'b1);
    send_pixel(12'd4095, 1'b0);
    send_pixel(12'd4094, 1'b1);

    setup(16'd2048, 16'd255);
    repeat (3) send_image($urandom_range(12, 2));

    while (pixels_sent < 700) begin
      case ($urandom_range(3))
        0: setup(16'($urandom), 16'($urandom_range(8, 1)));
        1: setup(16'($urandom_range(4095)), 16'($urandom));
        2: setup(16'($urandom_range(4095)), 16'($urandom_range(3)));
        default: setup(16'($urandom_range(65535, 4096)), 16'($urandom_range(20, 1)));
      endcase
      repeat ($urandom_range(5, 2)) send_image($urandom_range(20, 1));
    end

    drain();
    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #1000000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
